// ----- rtl/core/ght_pkg.sv -----
// shared types, codes and field widths of the generational handle table
`default_nettype none

package ght_pkg;

    // field widths of the request and result ports
    localparam int MODE_W      = 2;
    localparam int CTX_W       = 32;
    localparam int HIDX_W      = 32;
    localparam int GEN_W       = 32;
    localparam int PAYLOAD_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_INDEX_W = 10;

    // context register value after reset
    localparam logic [CTX_W-1:0] CTX_RESET = 32'd1;

    // request queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOREIGN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // one classified request waiting for the back end
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 foreign;
        logic [HIDX_W-1:0]    handle_index;
        logic [GEN_W-1:0]     generation;
        logic [PAYLOAD_W-1:0] payload;
    } entry_t;

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_INDEX_W-1:0] index;
        logic [GEN_W-1:0]       generation;
        logic [PAYLOAD_W-1:0]   payload;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/generational_handle_table.sv -----
// top level of the generational handle table
//
//  channel   signals                                    handshake
//  --------  -----------------------------------------  ---------------------------
//  request   start busy mode handle_context             taken when start && !busy
//            handle_index handle_generation new_payload
//  result    done status out_index out_generation       one-cycle strobe on done
//            out_payload
//  config    cfg_valid cfg_ready cfg_data               written on valid && ready
//
// in the back end each request is read from the slot tables and free stack in the
// read phase, then checked and written in the exec phase; that read-then-write on
// the synchronous rams means the back end finishes one request before it starts the next
// on an idle block a taken request passes the queue, the read phase and the exec phase, then done is registered;
// a two-entry queue lets the next request be taken meanwhile, busy is high while it is full
// reset is asynchronous active low; there is no clearing pass, the slots-used
// fill count and the free count guard every read of the tables
// the receiver cannot stall, so done is never held off
`default_nettype none

module generational_handle_table import ght_pkg::*; #(
    parameter int SLOTS        = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // request
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [CTX_W-1:0]       handle_context,
    input  wire logic [HIDX_W-1:0]      handle_index,
    input  wire logic [GEN_W-1:0]       handle_generation,
    input  wire logic [PAYLOAD_W-1:0]   new_payload,
    // result
    output logic                        done,
    output logic [STATUS_W-1:0]         status,
    output logic [OUT_INDEX_W-1:0]      out_index,
    output logic [GEN_W-1:0]            out_generation,
    output logic [PAYLOAD_W-1:0]        out_payload,
    // config
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CTX_W-1:0]       cfg_data
);

    logic [CTX_W-1:0] ctx_reg;
    logic [CTX_W-1:0] ctx_next;
    logic             head_valid;
    logic             pop;
    entry_t           head;
    result_t          result;

    // config register is always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        ctx_next = ctx_reg;
        if (cfg_valid && cfg_ready)
        begin
            ctx_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= CTX_RESET;
        end
        else
        begin
            ctx_reg <= ctx_next;
        end
    end

    // front: take requests, flag foreign contexts, queue them
    ght_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .mode              (mode),
        .handle_context    (handle_context),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .new_payload       (new_payload),
        .table_context_id  (ctx_reg),
        .pop               (pop),
        .busy              (busy),
        .head_valid        (head_valid),
        .head              (head)
    );

    // back: carry out allocate, lookup and release on the slot tables
    ght_back #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

    assign status         = result.status;
    assign out_index      = result.index;
    assign out_generation = result.generation;
    assign out_payload    = result.payload;

`ifndef SYNTHESIS
    // the back end reads and then executes each request, so results never come back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("results on consecutive cycles");

    // failed requests report nothing but their status
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |->
            ((out_index == '0) && (out_generation == '0) && (out_payload == '0)))
        else $error("failed request with nonzero result fields");

    // the queue only fills up behind a request just taken
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // allocate never hands out a payload word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (out_generation != '0)) |-> (out_payload == '0))
        else $error("allocate result carries a payload");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ght_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/ght_front.sv -----
// front end: request acceptance, context check and request queue
`default_nettype none

module ght_front import ght_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [CTX_W-1:0]     handle_context,
    input  wire logic [HIDX_W-1:0]    handle_index,
    input  wire logic [GEN_W-1:0]     handle_generation,
    input  wire logic [PAYLOAD_W-1:0] new_payload,
    input  wire logic [CTX_W-1:0]     table_context_id,
    input  wire logic                 pop,
    output logic                      busy,
    output logic                      head_valid,
    output entry_t                    head
);

    entry_t               q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push;
    entry_t               incoming;

    assign busy       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = start && !busy;
    assign head       = q_reg[rd_ptr_reg];

    // classify: the context is compared for every request; only handle operations act on the flag
    always_comb
    begin
        incoming.mode         = mode;
        incoming.foreign      = (handle_context != table_context_id);
        incoming.handle_index = handle_index;
        incoming.generation   = handle_generation;
        incoming.payload      = new_payload;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ght_back.sv -----
// back end: slot tables, free stack and the read-then-write sequencer
`default_nettype none

module ght_back import ght_pkg::*; #(
    parameter int SLOTS        = 1024,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  entry_t    head,
    output logic      pop,
    output logic      done,
    output result_t   result
);

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int META_W  = GEN_W + 1;
    localparam int STACK_W = GEN_W + IDX_W;

    localparam logic PH_READ = 1'b0;
    localparam logic PH_EXEC = 1'b1;

    logic             phase_reg;
    logic             phase_next;
    logic [CNT_W-1:0] fc_reg;
    logic [CNT_W-1:0] fc_next;
    logic [CNT_W-1:0] su_reg;
    logic [CNT_W-1:0] su_next;
    logic [CNT_W-1:0] fc_dec;
    logic             done_reg;
    logic             done_next;
    result_t          result_reg;
    result_t          result_next;

    logic [IDX_W-1:0]        head_idx;
    logic                    idx_hi;
    logic                    in_range;
    logic [63:0]             pay_in_wide;
    logic [63:0]             pay_out_wide;
    logic [31:0]             slot_wide;

    logic                    meta_we;
    logic [IDX_W-1:0]        meta_wr_addr;
    logic [META_W-1:0]       meta_wr_data;
    logic [META_W-1:0]       meta_rd_data;
    logic                    pay_we;
    logic [IDX_W-1:0]        pay_wr_addr;
    logic [PAYLOAD_BITS-1:0] pay_wr_data;
    logic [PAYLOAD_BITS-1:0] pay_rd_data;
    logic                    stk_we;
    logic [IDX_W-1:0]        stk_wr_addr;
    logic [STACK_W-1:0]      stk_wr_data;
    logic [STACK_W-1:0]      stk_rd_data;

    logic                    have;
    logic [IDX_W-1:0]        slot;
    logic [GEN_W-1:0]        slot_gen;
    logic [GEN_W-1:0]        gen_inc;
    logic                    meta_live;
    logic [GEN_W-1:0]        meta_gen;

    assign head_idx     = head.handle_index[IDX_W-1:0];
    assign idx_hi       = ((head.handle_index >> IDX_W) != '0);
    assign in_range     = !idx_hi && (CNT_W'(head_idx) < su_reg);
    assign fc_dec       = fc_reg - CNT_W'(1);
    assign meta_live    = meta_rd_data[META_W-1];
    assign meta_gen     = meta_rd_data[GEN_W-1:0];
    assign gen_inc      = meta_gen + GEN_W'(1);
    assign pay_in_wide  = {32'b0, head.payload};
    assign pay_wr_data  = pay_in_wide[PAYLOAD_BITS-1:0];
    assign pay_out_wide = 64'(pay_rd_data);
    assign slot_wide    = 32'(slot);
    assign pay_wr_addr  = slot;

    // live mark and generation per slot
    ght_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (meta_wr_addr),
        .wr_data (meta_wr_data),
        .rd_addr (head_idx),
        .rd_data (meta_rd_data)
    );

    // payload per slot
    ght_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_payload (
        .clk     (clk),
        .wr_en   (pay_we),
        .wr_addr (pay_wr_addr),
        .wr_data (pay_wr_data),
        .rd_addr (head_idx),
        .rd_data (pay_rd_data)
    );

    // free stack entries carry the index and the generation it will reuse
    ght_ram #(.WIDTH(STACK_W), .DEPTH(SLOTS)) u_stack (
        .clk     (clk),
        .wr_en   (stk_we),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (fc_dec[IDX_W-1:0]),
        .rd_data (stk_rd_data)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        fc_next      = fc_reg;
        su_next      = su_reg;
        done_next    = 1'b0;
        result_next  = '0;
        result_next.status = ST_INVALID;
        pop          = 1'b0;
        have         = 1'b0;
        slot         = head_idx;
        slot_gen     = '0;
        meta_we      = 1'b0;
        meta_wr_addr = head_idx;
        meta_wr_data = {1'b0, gen_inc};
        pay_we       = 1'b0;
        stk_we       = 1'b0;
        stk_wr_addr  = fc_reg[IDX_W-1:0];
        stk_wr_data  = {gen_inc, head_idx};

        if (phase_reg == PH_READ)
        begin
            if (head_valid)
            begin
                phase_next = PH_EXEC;
            end
        end
        else
        begin
            phase_next = PH_READ;
            pop        = 1'b1;
            done_next  = 1'b1;
            case (head.mode)
                MODE_ALLOC:
                begin
                    if (fc_reg != '0)
                    begin
                        slot     = stk_rd_data[IDX_W-1:0];
                        slot_gen = stk_rd_data[STACK_W-1:IDX_W];
                        fc_next  = fc_dec;
                        have     = 1'b1;
                    end
                    else if (su_reg < CNT_W'(SLOTS))
                    begin
                        slot     = su_reg[IDX_W-1:0];
                        slot_gen = '0;
                        su_next  = su_reg + CNT_W'(1);
                        have     = 1'b1;
                    end
                    if (have)
                    begin
                        meta_we                = 1'b1;
                        meta_wr_addr           = slot;
                        meta_wr_data           = {1'b1, slot_gen};
                        pay_we                 = 1'b1;
                        result_next.status     = ST_OK;
                        result_next.index      = slot_wide[OUT_INDEX_W-1:0];
                        result_next.generation = slot_gen;
                    end
                    else
                    begin
                        result_next.status = ST_FULL;
                    end
                end
                MODE_LOOKUP, MODE_RELEASE:
                begin
                    if (head.foreign)
                    begin
                        result_next.status = ST_FOREIGN;
                    end
                    else if (in_range && meta_live && (meta_gen == head.generation))
                    begin
                        result_next.status = ST_OK;
                        if (head.mode == MODE_LOOKUP)
                        begin
                            result_next.payload = pay_out_wide[PAYLOAD_W-1:0];
                        end
                        else
                        begin
                            meta_we = 1'b1;
                            if (fc_reg < CNT_W'(SLOTS))
                            begin
                                stk_we  = 1'b1;
                                fc_next = fc_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    result_next.status = ST_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_READ;
            fc_reg    <= '0;
            su_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            fc_reg    <= fc_next;
            su_reg    <= su_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench of the generational handle table
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam int SLOTS = 1024;
    // fourth mode code, no operation behind it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side, all driven from time zero
    logic                 start = 1'b0;
    logic                 busy;
    logic [MODE_W-1:0]    mode = MODE_ALLOC;
    logic [CTX_W-1:0]     handle_context = '0;
    logic [HIDX_W-1:0]    handle_index = '0;
    logic [GEN_W-1:0]     handle_generation = '0;
    logic [PAYLOAD_W-1:0] new_payload = '0;

    // result side
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [OUT_INDEX_W-1:0] out_index;
    logic [GEN_W-1:0]       out_generation;
    logic [PAYLOAD_W-1:0]   out_payload;

    // context register write channel
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CTX_W-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    generational_handle_table uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .handle_context    (handle_context),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .new_payload       (new_payload),
        .done              (done),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .out_payload       (out_payload),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------
    // shadow copy of the table: context register, slot arrays, free stack
    // ------------------------------------------------------------------
    logic [CTX_W-1:0]       context_reg = CTX_RESET;
    bit [PAYLOAD_W-1:0]     slot_payload [SLOTS];
    bit [GEN_W-1:0]         slot_gen [SLOTS];
    bit                     slot_live [SLOTS];
    bit [OUT_INDEX_W-1:0]   free_list [SLOTS];
    int unsigned            free_depth = 0;
    int unsigned            slots_used = 0;

    // results still owed by the block, oldest first
    result_t pending_results [$];
    int      fail_count = 0;
    // random sender gaps on or off for the current phase
    bit      gaps_on = 1'b1;

    // handle validation: context first, then range, then live mark and generation
    function automatic logic [STATUS_W-1:0] handle_status(input logic [CTX_W-1:0] ctx,
                                                          input logic [HIDX_W-1:0] hidx,
                                                          input logic [GEN_W-1:0] hgen);
        if (ctx != context_reg)
            return ST_FOREIGN;
        if (hidx >= slots_used)
            return ST_INVALID;
        if (!slot_live[hidx] || slot_gen[hidx] != hgen)
            return ST_INVALID;
        return ST_OK;
    endfunction

    // applies one request to the shadow table and returns the result it owes
    function automatic result_t table_apply(input logic [MODE_W-1:0] m,
                                            input logic [CTX_W-1:0] ctx,
                                            input logic [HIDX_W-1:0] hidx,
                                            input logic [GEN_W-1:0] hgen,
                                            input logic [PAYLOAD_W-1:0] pay);
        result_t r;
        logic [OUT_INDEX_W-1:0] s;
        bit have;
        r = '0;
        r.status = ST_INVALID;
        s = '0;
        case (m)
            MODE_ALLOC: begin
                have = 1'b1;
                // freed slots are reused last-in first-out before fresh ones
                if (free_depth > 0) begin
                    free_depth--;
                    s = free_list[free_depth];
                end
                else if (slots_used < SLOTS) begin
                    s = slots_used[OUT_INDEX_W-1:0];
                    slots_used++;
                    slot_gen[s] = '0;
                end
                else
                    have = 1'b0;
                if (have) begin
                    slot_payload[s] = pay;
                    slot_live[s]    = 1'b1;
                    r.status        = ST_OK;
                    r.index         = s;
                    r.generation    = slot_gen[s];
                end
                else
                    r.status = ST_FULL;
            end
            MODE_LOOKUP: begin
                r.status = handle_status(ctx, hidx, hgen);
                if (r.status == ST_OK)
                    r.payload = slot_payload[hidx];
            end
            MODE_RELEASE: begin
                r.status = handle_status(ctx, hidx, hgen);
                if (r.status == ST_OK) begin
                    s = hidx[OUT_INDEX_W-1:0];
                    slot_live[s] = 1'b0;
                    slot_gen[s]  = slot_gen[s] + 1'b1;
                    free_list[free_depth] = s;
                    free_depth++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // random live slot of the shadow table, -1 when there is none
    function automatic int pick_live();
        int cand [$];
        for (int i = 0; i < slots_used; i++)
            if (slot_live[i])
                cand.insert(cand.size(), i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // result checker: every done strobe is matched against the oldest owed result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", status);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (out_index !== want.index) begin
                    $error("out_index: expected %0d, got %0d", want.index, out_index);
                    fail_count++;
                end
                if (out_generation !== want.generation) begin
                    $error("out_generation: expected %0h, got %0h",
                           want.generation, out_generation);
                    fail_count++;
                end
                if (out_payload !== want.payload) begin
                    $error("out_payload: expected %0h, got %0h", want.payload, out_payload);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared driving tasks; each is entered and left just after a rising edge
    // ------------------------------------------------------------------

    // drives one request and holds it until the block takes it
    task automatic send_request(input logic [MODE_W-1:0] m,
                                input logic [CTX_W-1:0] ctx,
                                input logic [HIDX_W-1:0] hidx,
                                input logic [GEN_W-1:0] hgen,
                                input logic [PAYLOAD_W-1:0] pay);
        start             <= 1'b1;
        mode              <= m;
        handle_context    <= ctx;
        handle_index      <= hidx;
        handle_generation <= hgen;
        new_payload       <= pay;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        // taken at this edge, so the shadow table moves on now
        pending_results.insert(pending_results.size(),
                               table_apply(m, ctx, hidx, hgen, pay));
    endtask

    // random burst of idle cycles on the request side
    task automatic sender_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop sending and wait until every owed result has come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // context register write, only with the block drained
    task automatic write_context(input logic [CTX_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        context_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_gapped(input logic [MODE_W-1:0] m,
                               input logic [CTX_W-1:0] ctx,
                               input logic [HIDX_W-1:0] hidx,
                               input logic [GEN_W-1:0] hgen,
                               input logic [PAYLOAD_W-1:0] pay);
        sender_gap();
        send_request(m, ctx, hidx, hgen, pay);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, every mode and the handle rejection cases, reset context
    task automatic test_directed();
        // empty table: any index is out of range
        send_gapped(MODE_LOOKUP, context_reg, 32'd0, 32'd0, 32'd0);
        send_gapped(MODE_ALLOC, '0, '0, '0, 32'h0000_0000);
        send_gapped(MODE_ALLOC, '1, '1, '1, 32'hFFFF_FFFF);
        send_gapped(MODE_LOOKUP, context_reg, 32'd0, slot_gen[0], $urandom);
        send_gapped(MODE_LOOKUP, context_reg, 32'd1, slot_gen[1], $urandom);
        // foreign contexts at both extremes
        send_gapped(MODE_LOOKUP, 32'h0000_0000, 32'd0, slot_gen[0], '0);
        send_gapped(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd1, slot_gen[1], '0);
        send_gapped(MODE_RELEASE, 32'h8000_0000, 32'd1, slot_gen[1], '0);
        // index out of range: just past the used slots and the top index
        send_gapped(MODE_LOOKUP, context_reg, 32'd2, 32'd0, '0);
        send_gapped(MODE_LOOKUP, context_reg, 32'hFFFF_FFFF, 32'd0, '0);
        send_gapped(MODE_RELEASE, context_reg, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        // wrong generation on a live slot
        send_gapped(MODE_LOOKUP, context_reg, 32'd0, 32'hFFFF_FFFF, '0);
        // release, then double release and a stale lookup
        send_gapped(MODE_RELEASE, context_reg, 32'd0, slot_gen[0], '0);
        send_gapped(MODE_RELEASE, context_reg, 32'd0, slot_gen[0] - 1'b1, '0);
        send_gapped(MODE_LOOKUP, context_reg, 32'd0, slot_gen[0] - 1'b1, '0);
        // freed slot comes back with the next generation
        send_gapped(MODE_ALLOC, $urandom, $urandom, $urandom, 32'hA5A5_5A5A);
        send_gapped(MODE_LOOKUP, context_reg, 32'd0, slot_gen[0], '0);
        // unused mode, once with every field at its top and once with a valid handle
        send_gapped(MODE_UNUSED, '1, '1, '1, '1);
        send_gapped(MODE_UNUSED, context_reg, 32'd0, slot_gen[0], $urandom);
    endtask

    // context zero is a legal register value; then the all-ones value
    task automatic test_context_settings();
        write_context(32'h0000_0000);
        send_gapped(MODE_LOOKUP, 32'h0000_0000, 32'd1, slot_gen[1], '0);
        send_gapped(MODE_LOOKUP, 32'h0000_0001, 32'd1, slot_gen[1], '0);
        write_context(32'hFFFF_FFFF);
        send_gapped(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0, slot_gen[0], '0);
        send_gapped(MODE_LOOKUP, 32'h0000_0000, 32'd0, slot_gen[0], '0);
    endtask

    // mostly well-formed handle traffic, some foreign, stale and garbage handles
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned        sent;
        int                 pick;
        int                 live_idx;
        int                 s;
        logic [MODE_W-1:0]  m;
        logic [CTX_W-1:0]   ctx;
        logic [CTX_W-1:0]   flip;
        logic [HIDX_W-1:0]  hidx;
        logic [GEN_W-1:0]   hgen;
        logic [PAYLOAD_W-1:0] pay;
        sent = 0;
        while (sent < n_items) begin
            pick     = $urandom_range(0, 99);
            live_idx = pick_live();
            m        = $urandom_range(0, 1) ? MODE_LOOKUP : MODE_RELEASE;
            ctx      = context_reg;
            hidx     = $urandom;
            hgen     = $urandom;
            pay      = $urandom;
            if (pick < 30 || (pick < 72 && live_idx < 0))
                m = MODE_ALLOC;
            else if (pick < 72) begin
                // valid handle of a live slot
                m    = (pick < 55) ? MODE_LOOKUP : MODE_RELEASE;
                hidx = live_idx;
                hgen = slot_gen[live_idx];
            end
            else if (pick < 80 && slots_used > 0) begin
                // stale handle: old generation, or a slot no longer live
                s    = $urandom_range(0, slots_used - 1);
                hidx = s;
                hgen = (slot_live[s] || $urandom_range(0, 1)) ? slot_gen[s] - 1'b1
                                                              : slot_gen[s];
            end
            else if (pick < 87) begin
                // otherwise good handle carrying a different context
                flip = $urandom;
                if (flip == '0)
                    flip = 32'd1;
                ctx = context_reg ^ flip;
                if (live_idx >= 0) begin
                    hidx = live_idx;
                    hgen = slot_gen[live_idx];
                end
            end
            else if (pick < 94) begin
                // index around and beyond the table end
                if ($urandom_range(0, 1))
                    hidx = $urandom_range(0, SLOTS + 3);
            end
            else
                m = MODE_UNUSED;
            send_gapped(m, ctx, hidx, hgen, pay);
            if (m != MODE_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_context_settings();

        // random context first, then both extremes, then back to the reset value
        write_context($urandom | 32'd1);
        test_random_traffic(90);
        write_context(32'h0000_0000);
        test_random_traffic(90);
        write_context(32'hFFFF_FFFF);
        test_random_traffic(90);
        write_context(CTX_RESET);
        gaps_on = 1'b0;
        test_random_traffic(90);

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ght_pkg.sv
rtl/core/ght_ram.sv
rtl/core/ght_front.sv
rtl/core/ght_back.sv
rtl/core/generational_handle_table.sv
test/tb_top.sv
